@@ design/fmr_pkg.sv @@
// Shared types, constants and helper functions of the two-mode float remainder.
package fmr_pkg;

  localparam int QueueDepth = 2;

  localparam logic [31:0] DefaultNan = 32'h7FC0_0000;
  localparam logic [31:0] QuietBit   = 32'h0040_0000;
  localparam logic [7:0]  ExpAll     = 8'hFF;

  // One classified item as it travels from the front to the back.
  typedef struct packed {
    logic               special;   // result is known, no arithmetic needed
    logic [31:0]        spec_res;
    logic               mode;      // 0 floored, 1 truncated
    logic               lt;        // |x| < |y|, remainder is x itself
    logic               eq;        // |x| == |y|, remainder is a signed zero
    logic [31:0]        x_bits;
    logic [31:0]        y_bits;
    logic [23:0]        mx;
    logic [23:0]        my;
    logic signed [9:0]  ey;
    logic [8:0]         exp_gap;   // exponent difference ex - ey
  } fmr_entry_t;

  // Leading zeros of a 24-bit value, 24 when the value is zero.
  function automatic logic [4:0] lzc24(input logic [23:0] v);
    logic [4:0] lz;
    lz = 5'd24;
    for (int i = 0; i < 24; i++) begin
      if (v[i]) lz = 5'(23 - i);
    end
    return lz;
  endfunction

  // Leading zeros of a 27-bit value, 27 when the value is zero.
  function automatic logic [4:0] lzc27(input logic [26:0] v);
    logic [4:0] lz;
    lz = 5'd27;
    for (int i = 0; i < 27; i++) begin
      if (v[i]) lz = 5'(26 - i);
    end
    return lz;
  endfunction

  function automatic logic is_nan(input logic [31:0] v);
    return (v[30:23] == ExpAll) && (v[22:0] != 23'd0);
  endfunction

endpackage

@@ design/fmr_front.sv @@
// Front end: classifies each operand pair and unpacks the significands.
module fmr_front
  import fmr_pkg::*;
(
  input  logic        mode_i,
  input  logic [31:0] dividend_bits_i,
  input  logic [31:0] divisor_bits_i,
  output fmr_entry_t  entry_o
);

  logic [31:0]       x, y;
  logic [4:0]        lzx, lzy;
  logic [23:0]       mx, my;
  logic signed [9:0] ex, ey;

  assign x = dividend_bits_i;
  assign y = divisor_bits_i;

  // Unpack both significands with the hidden bit at bit 23; subnormals are normalized.
  always_comb begin
    lzx = lzc24({x[22:0], 1'b1});
    lzy = lzc24({y[22:0], 1'b1});
    if (x[30:23] == 8'd0) begin
      mx = {1'b0, x[22:0]} << (lzx + 5'd1);
      ex = -$signed({5'd0, lzx});
    end else begin
      mx = {1'b1, x[22:0]};
      ex = $signed({2'd0, x[30:23]});
    end
    if (y[30:23] == 8'd0) begin
      my = {1'b0, y[22:0]} << (lzy + 5'd1);
      ey = -$signed({5'd0, lzy});
    end else begin
      my = {1'b1, y[22:0]};
      ey = $signed({2'd0, y[30:23]});
    end
  end

  // Classify: zero divisor, NaNs and infinities are settled here.
  always_comb begin
    entry_o          = '0;
    entry_o.mode     = mode_i;
    entry_o.x_bits   = x;
    entry_o.y_bits   = y;
    entry_o.mx       = mx;
    entry_o.my       = my;
    entry_o.ey       = ey;
    entry_o.exp_gap  = 9'(ex - ey);
    entry_o.lt       = x[30:0] < y[30:0];
    entry_o.eq       = x[30:0] == y[30:0];
    if (y[30:0] == 31'd0) begin
      entry_o.special  = 1'b1;
      entry_o.spec_res = 32'd0;
    end else if (is_nan(x)) begin
      entry_o.special  = 1'b1;
      entry_o.spec_res = x | QuietBit;
    end else if (is_nan(y)) begin
      entry_o.special  = 1'b1;
      entry_o.spec_res = y | QuietBit;
    end else if (x[30:23] == ExpAll) begin
      entry_o.special  = 1'b1;
      entry_o.spec_res = DefaultNan;
    end else if (y[30:23] == ExpAll) begin
      entry_o.special  = 1'b1;
      entry_o.spec_res = (!mode_i && x[30:0] != 31'd0 && x[31] != y[31]) ? y : x;
    end
  end

endmodule

@@ design/fmr_queue.sv @@
// Short first-in first-out queue between the front and the back.
module fmr_queue
  import fmr_pkg::*;
#(
  parameter int Depth = QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  fmr_entry_t data_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       valid_o,
  output fmr_entry_t data_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  fmr_entry_t      mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = cnt_q == CntW'(Depth);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_q];

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (pop_i)  rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_o |-> !pop_i) else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth)) else $error("queue count out of range");

endmodule

@@ design/fmr_back.sv @@
// Back end: iterative exact remainder, packing and the floored-mode correction add.
module fmr_back
  import fmr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  fmr_entry_t  q_data_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] result_bits_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOOP = 3'd1;
  localparam logic [2:0] S_NORM = 3'd2;
  localparam logic [2:0] S_ADD1 = 3'd3;
  localparam logic [2:0] S_ADD2 = 3'd4;

  localparam int StepsPerCycle = 8;

  logic [2:0]        state_q, state_d;
  logic [8:0]        cnt_q, cnt_d;
  logic [24:0]       rem_q, rem_d;
  logic [23:0]       my_q, my_d;
  logic signed [9:0] ey_q, ey_d;
  logic              sx_q, sx_d;
  logic              mode_q, mode_d;
  logic [31:0]       y_q, y_d;
  logic [31:0]       r_q, r_d;
  logic [26:0]       diff_q, diff_d;
  logic [7:0]        eb_q, eb_d;
  logic              out_valid_q;
  logic [31:0]       out_q;
  logic              out_load;
  logic [31:0]       out_val;

  // Working signals of the datapath.
  logic [24:0]       walk, part, fin;
  logic [8:0]        steps;
  logic [23:0]       nt, nrm;
  logic [4:0]        lz;
  logic signed [9:0] rexp, rsh;
  logic              add_need;
  logic [7:0]        ea, eb, sh, lim, shl;
  logic [23:0]       ma, mb;
  logic [4:0]        shc;
  logic [53:0]       full;
  logic [26:0]       dn;
  logic [7:0]        ef, ee;
  logic              inc;

  assign q_pop_o       = (state_q == S_IDLE) && q_valid_i && !out_valid_q;
  assign out_valid_o   = out_valid_q;
  assign result_bits_o = out_q;

  // Up to eight shift-subtract steps of the long division per cycle.
  always_comb begin
    walk = rem_q;
    part = '0;
    for (int i = 0; i < StepsPerCycle; i++) begin
      if (9'(i) < cnt_q) begin
        part = (walk >= {1'b0, my_q}) ? walk - {1'b0, my_q} : walk;
        walk = {part[23:0], 1'b0};
      end
    end
    steps = (cnt_q > 9'(StepsPerCycle)) ? 9'(StepsPerCycle) : cnt_q;
    fin   = (rem_q >= {1'b0, my_q}) ? rem_q - {1'b0, my_q} : rem_q;
  end

  // Normalize and pack the exact remainder.
  always_comb begin
    nt   = rem_q[23:0];
    lz   = lzc24(nt);
    nrm  = nt << lz;
    rexp = ey_q - $signed({5'd0, lz});
    rsh  = 10'sd1 - rexp;
  end

  // Alignment of the correction add, |y| - |r|; the sequencer does the subtraction.
  always_comb begin
    add_need = !mode_q && (r_q[30:0] != 31'd0) && (r_q[31] != y_q[31]);
    ea   = (r_q[30:23] == 8'd0) ? 8'd1 : r_q[30:23];
    eb   = (y_q[30:23] == 8'd0) ? 8'd1 : y_q[30:23];
    ma   = {r_q[30:23] != 8'd0, r_q[22:0]};
    mb   = {y_q[30:23] != 8'd0, y_q[22:0]};
    sh   = eb - ea;
    shc  = (sh > 8'd27) ? 5'd27 : sh[4:0];
    full = {ma, 3'b000, 27'd0} >> shc;
  end

  // Normalization and round to nearest even of the difference.
  always_comb begin
    lim = eb_q - 8'd1;
    shl = ({3'd0, lzc27(diff_q)} <= lim) ? {3'd0, lzc27(diff_q)} : lim;
    dn  = diff_q << shl;
    ee  = eb_q - shl;
    ef  = dn[26] ? ee : 8'd0;
    inc = dn[2] & (dn[1] | dn[0] | dn[3]);
  end

  // Sequencer of one item.
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    rem_d    = rem_q;
    my_d     = my_q;
    ey_d     = ey_q;
    sx_d     = sx_q;
    mode_d   = mode_q;
    y_d      = y_q;
    r_d      = r_q;
    diff_d   = diff_q;
    eb_d     = eb_q;
    out_load = 1'b0;
    out_val  = r_q;
    case (state_q)
      S_IDLE: begin
        if (q_pop_o) begin
          sx_d   = q_data_i.x_bits[31];
          mode_d = q_data_i.mode;
          y_d    = q_data_i.y_bits;
          if (q_data_i.special) begin
            out_load = 1'b1;
            out_val  = q_data_i.spec_res;
          end else if (q_data_i.lt) begin
            r_d     = q_data_i.x_bits;
            state_d = S_ADD1;
          end else if (q_data_i.eq) begin
            out_load = 1'b1;
            out_val  = {q_data_i.x_bits[31], 31'd0};
          end else begin
            rem_d   = {1'b0, q_data_i.mx};
            my_d    = q_data_i.my;
            ey_d    = q_data_i.ey;
            cnt_d   = q_data_i.exp_gap;
            state_d = S_LOOP;
          end
        end
      end
      S_LOOP: begin
        if (cnt_q == 9'd0) begin
          rem_d   = fin;
          state_d = S_NORM;
        end else begin
          rem_d = walk;
          cnt_d = cnt_q - steps;
        end
      end
      S_NORM: begin
        if (nt == 24'd0) begin
          out_load = 1'b1;
          out_val  = {sx_q, 31'd0};
          state_d  = S_IDLE;
        end else begin
          if (rexp > 10'sd0) r_d = {sx_q, rexp[7:0], nrm[22:0]};
          else if (rsh > 10'sd24) r_d = {sx_q, 31'd0};
          else r_d = {sx_q, 8'd0, 23'(nrm >> rsh[4:0])};
          state_d = S_ADD1;
        end
      end
      S_ADD1: begin
        if (add_need) begin
          diff_d  = {mb, 3'b000} - (full[53:27] | {26'd0, |full[26:0]});
          eb_d    = eb;
          state_d = S_ADD2;
        end else begin
          out_load = 1'b1;
          out_val  = r_q;
          state_d  = S_IDLE;
        end
      end
      S_ADD2: begin
        out_load = 1'b1;
        out_val  = {y_q[31], {ef, dn[25:3]} + 31'(inc)};
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    rem_q  <= rem_d;
    my_q   <= my_d;
    ey_q   <= ey_d;
    sx_q   <= sx_d;
    mode_q <= mode_d;
    y_q    <= y_d;
    r_q    <= r_d;
    diff_q <= diff_d;
    eb_q   <= eb_d;
    if (out_load) out_q <= out_val;
  end

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !out_valid_q) else $error("result register overwritten");
  a_loop_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOOP && cnt_q != 9'd0) |=> (state_q == S_LOOP && cnt_q < $past(cnt_q)))
    else $error("division loop made no progress");
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LOOP |-> rem_q < {my_q, 1'b0}) else $error("partial remainder too large");
  a_norm_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_NORM |-> rem_q[23:0] < my_q) else $error("final remainder not reduced");

endmodule

@@ design/float_remainder_two_mode.sv @@
// Top level of the two-mode binary32 remainder unit.
// Takes a dividend and divisor beat and returns one binary32 remainder beat: the exact
// truncating remainder (mode 1) or the floored remainder with the divisor's sign (mode 0),
// with NaN, infinity and subnormal cases as in C fmodf plus IEEE addition; a zero divisor gives +0.
// Items with an exact reduction go through the division loop of the back end, which does
// up to eight shift-subtract steps per cycle over the exponent difference of the operands
// (up to 276); special cases skip it. A two-entry queue lets the front accept beats while
// the back works, and the result register holds a beat until taken.
module float_remainder_two_mode
  import fmr_pkg::*;
#(
  parameter int QDepth = QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_mode_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] dividend_bits_i,
  input  logic [31:0] divisor_bits_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] result_bits_o
);

  logic       mode_q;
  logic       q_full, q_valid, q_pop, push;
  fmr_entry_t f_entry, q_entry;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_full;
  assign push        = in_valid_i && !q_full;

  // Mode register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mode_q <= cfg_mode_i;
    end
  end

  fmr_front u_front (
    .mode_i          (mode_q),
    .dividend_bits_i (dividend_bits_i),
    .divisor_bits_i  (divisor_bits_i),
    .entry_o         (f_entry)
  );

  fmr_queue #(.Depth(QDepth)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (f_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_entry)
  );

  fmr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_data_i      (q_entry),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .result_bits_o (result_bits_o)
  );

endmodule

@@ tb/float_remainder_two_mode_tb.sv @@
// Self-checking testbench for the two-mode binary32 remainder unit.
module float_remainder_two_mode_tb
  import fmr_pkg::*;
();

  localparam int WatchdogLimit = 4000;
  localparam int DrainCycles   = 60;
  localparam int RandomItems   = 1000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_mode_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [31:0] dividend_bits_i;
  logic [31:0] divisor_bits_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [31:0] result_bits_o;

  // Predictor state and the store of pending remainders.
  logic        mode_shadow;
  logic [31:0] expected_results[$];
  int          error_count;
  int          items_sent;
  int          results_seen;
  int          idle_cycles;
  bit          no_gaps;

  float_remainder_two_mode dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_mode_i     (cfg_mode_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .dividend_bits_i(dividend_bits_i),
    .divisor_bits_i (divisor_bits_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_bits_o  (result_bits_o)
  );

  // Clock with an 8-unit period.
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  function automatic logic nan_bits(input logic [31:0] v);
    return v[30:0] > 31'h7F80_0000;
  endfunction

  // Integer significand with the hidden bit at 23; subnormals are normalized.
  function automatic void unpack_mag(input logic [31:0] v, output logic [31:0] sig,
                                     output int ex);
    logic [31:0] probe;
    ex = int'(v[30:23]);
    sig = {9'd0, v[22:0]};
    if (ex == 0) begin
      probe = v << 9;
      while (!probe[31]) begin
        ex--;
        probe = probe << 1;
      end
      sig = sig << (1 - ex);
    end else begin
      sig[23] = 1'b1;
    end
  endfunction

  // Exact truncating remainder by shift and subtract; the divisor is nonzero.
  function automatic logic [31:0] fmod_trunc(input logic [31:0] ux, input logic [31:0] uy);
    logic [31:0] sx;
    logic [31:0] mx;
    logic [31:0] my;
    logic [31:0] diff;
    int          ex;
    int          ey;
    sx = ux & 32'h8000_0000;
    if (nan_bits(ux)) return ux | QuietBit;
    if (nan_bits(uy)) return uy | QuietBit;
    if (ux[30:0] == 31'h7F80_0000) return DefaultNan;
    if (ux[30:0] < uy[30:0]) return ux;
    if (ux[30:0] == uy[30:0]) return sx;
    unpack_mag({1'b0, ux[30:0]}, mx, ex);
    unpack_mag({1'b0, uy[30:0]}, my, ey);
    while (ex > ey) begin
      diff = mx - my;
      if (!diff[31]) begin
        if (diff == 32'd0) return sx;
        mx = diff;
      end
      mx = mx << 1;
      ex--;
    end
    diff = mx - my;
    if (!diff[31]) begin
      if (diff == 32'd0) return sx;
      mx = diff;
    end
    while ((mx >> 23) == 32'd0) begin
      mx = mx << 1;
      ex--;
    end
    if (ex > 0) begin
      mx = mx - 32'h0080_0000;
      mx = mx | (32'(ex) << 23);
    end else begin
      mx = mx >> (1 - ex);
    end
    return mx | sx;
  endfunction

  // Adds the divisor to a remainder of opposite sign, rounded to nearest even.
  // The remainder is smaller in magnitude, so this is |y| - |r| with y's sign.
  function automatic logic [31:0] floored_fix(input logic [31:0] r, input logic [31:0] y);
    logic [63:0] a_val;
    logic [63:0] b_full;
    logic [63:0] b_val;
    logic [63:0] diff;
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    logic [31:0] my;
    logic [31:0] mr;
    logic        sticky;
    int          ey;
    int          er;
    int          exp_gap;
    int          lead;
    int          be;
    int          sh;
    if (y[30:23] == ExpAll) return y;
    my = {8'd0, (y[30:23] != 8'd0), y[22:0]};
    mr = {8'd0, (r[30:23] != 8'd0), r[22:0]};
    ey = (y[30:23] == 8'd0) ? 1 : int'(y[30:23]);
    er = (r[30:23] == 8'd0) ? 1 : int'(r[30:23]);
    exp_gap = ey - er;
    a_val = 64'(my) << 40;
    b_full = 64'(mr) << 40;
    if (exp_gap >= 64) begin
      b_val = 64'd0;
      sticky = (mr != 32'd0);
    end else begin
      b_val = b_full >> exp_gap;
      sticky = ((b_full & ((64'd1 << exp_gap) - 64'd1)) != 64'd0);
    end
    b_val = b_val | 64'(sticky);
    diff = a_val - b_val;
    lead = 0;
    for (int i = 0; i < 64; i++) begin
      if (diff[i]) lead = i;
    end
    be = lead + ey - 63;
    sh = lead - 23;
    if (be < 1) begin
      sh = sh + (1 - be);
      be = 1;
    end
    if (sh > 0) begin
      q = diff >> sh;
      rem = diff & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && q[0])) q = q + 64'd1;
    end else begin
      q = diff << (-sh);
    end
    // A carry out of the significand moves into the exponent field by itself.
    return {y[31], 31'((32'(be - 1) << 23) + q[31:0])};
  endfunction

  function automatic logic [31:0] predict_remainder(input logic [31:0] x, input logic [31:0] y);
    logic [31:0] r;
    if (y[30:0] == 31'd0) return 32'd0;
    r = fmod_trunc(x, y);
    if (!mode_shadow && !nan_bits(r) && r[30:0] != 31'd0 && (r[31] != y[31]))
      r = floored_fix(r, y);
    return r;
  endfunction

  // Sends one dividend and divisor beat after a random gap, or at once while no_gaps is set.
  task automatic send_pair(input logic [31:0] x, input logic [31:0] y);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    dividend_bits_i <= x;
    divisor_bits_i  <= y;
    do @(posedge clk_i); while (in_stall_o);
    expected_results.push_back(predict_remainder(x, y));
    items_sent++;
  endtask

  // Waits until every remainder has come back and the back end has settled.
  task automatic drain;
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic m);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_mode_i  <= m;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    mode_shadow = m;
  endtask

  // Random operand drawn from a class of interesting encodings.
  function automatic logic [31:0] random_operand;
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 15))
      0:       v[30:23] = 8'h00;
      1:       v[30:23] = 8'hFF;
      2:       v[30:0]  = 31'd0;
      3:       v[30:0]  = 31'h7F80_0000;
      default: v[30:23] = 8'($urandom_range(1, 254));
    endcase
    return v;
  endfunction

  // Edge cases of the fields, run once in each mode.
  task automatic test_directed(input logic m);
    write_mode(m);
    send_pair(32'h4120_0000, 32'h4040_0000);  // 10 rem 3
    send_pair(32'hC120_0000, 32'h4040_0000);  // -10 rem 3
    send_pair(32'h4120_0000, 32'hC040_0000);  // 10 rem -3
    send_pair(32'hC120_0000, 32'hC040_0000);
    send_pair(32'h3F80_0000, 32'h0000_0000);  // zero divisor
    send_pair(32'h7FA0_0001, 32'h8000_0000);  // NaN over negative zero
    send_pair(32'hFF80_1234, 32'h4000_0000);  // signaling NaN dividend
    send_pair(32'h3F80_0000, 32'h7F80_0055);  // NaN divisor
    send_pair(32'h7F80_0000, 32'h4000_0000);  // infinite dividend
    send_pair(32'hFF80_0000, 32'h7F80_0000);
    send_pair(32'hC000_0000, 32'h7F80_0000);  // infinite divisor, sign differs
    send_pair(32'h4000_0000, 32'hFF80_0000);
    send_pair(32'h8000_0000, 32'h7F80_0000);  // zero dividend
    send_pair(32'hC0A0_0000, 32'h40A0_0000);  // equal magnitudes
    send_pair(32'h8000_0003, 32'h4000_0000);  // smaller dividend, subnormal
    send_pair(32'h7F7F_FFFF, 32'h0000_0001);  // widest exponent gap
    send_pair(32'hFF7F_FFFF, 32'h0000_0003);
    send_pair(32'h007F_FFFF, 32'h8000_0007);  // subnormal operands
    send_pair(32'h4B80_0001, 32'hC000_0000);
    send_pair(32'h3F80_0001, 32'hBF80_0000);  // tiny result near the divisor
    send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pair(32'h0000_0000, 32'h0000_0000);
    send_pair(32'h7F7F_FFFF, 32'hFF7F_FFFE);
  endtask

  // Random pairs; every 100 items the gaps go off with odds of one in four; the mode flips at i % 250 == 125.
  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      if ((i % 250) == 125) write_mode(~mode_shadow);
      send_pair(random_operand(), random_operand());
    end
    no_gaps = 1'b0;
  endtask

  // The sender holds off until the unit has emptied, then restarts.
  task automatic test_pause;
    for (int i = 0; i < 8; i++) send_pair(random_operand(), random_operand());
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    for (int i = 0; i < 8; i++) send_pair(random_operand(), random_operand());
  endtask

  // Output side: stall for a random number of cycles before each beat, none while no_gaps is set.
  initial begin
    int hold;
    out_stall_i = 1'b1;
    @(posedge rst_ni);
    forever begin
      hold = no_gaps ? 0 : $urandom_range(0, 7);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Compare each accepted result with the oldest pending remainder.
  always @(posedge clk_i) begin
    logic [31:0] want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("result_bits: no beat expected, got %h", result_bits_o);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (result_bits_o !== want) begin
          $error("result_bits: expected %h, actual %h", want, result_bits_o);
          error_count++;
        end
      end
    end
  end

  // Watchdog over cycles in which no beat moves on any channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("Timeout with %0d results pending", expected_results.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_mode_i      = 1'b0;
    in_valid_i      = 1'b0;
    dividend_bits_i = 32'd0;
    divisor_bits_i  = 32'd0;
    mode_shadow     = 1'b0;
    error_count     = 0;
    items_sent      = 0;
    results_seen    = 0;
    idle_cycles     = 0;
    no_gaps         = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed(1'b1);
    test_directed(1'b0);
    test_pause();
    test_random(RandomItems);
    drain();

    $display("Sent %0d operand pairs in floored and truncated modes, checked %0d results,",
             items_sent, results_seen);
    $display("covering NaN, infinity, zero divisor, subnormal and wide exponent gaps.");
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
